// ----- design/assert_macros.svh -----
// Assertion macros shared by the convolution RTL.
// Included by the controller and the datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- design/cnv3_pkg.sv -----
// Shared types and constants for the 3x3 convolution block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package cnv3_pkg;

    localparam int SIZE_BITS       = 11;
    localparam int SIZE_MIN        = 3;
    localparam int SIZE_MAX        = 1024;
    localparam int CFG_INDEX_BITS  = 3;
    localparam int CFG_DATA_BITS   = 36;
    localparam int PIXEL_PORT_BITS = 16;
    localparam int TAP_BITS        = 4;
    localparam int TAP_COUNT       = 9;
    localparam int TAPS_BITS       = TAP_BITS * TAP_COUNT;
    localparam int SCALE_BITS      = 16;
    localparam int BIAS_BITS       = 20;
    localparam int BIAS9_BITS      = BIAS_BITS + 4;
    localparam int VALUE_BITS      = 40;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_TAPS  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_SCALE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TAP_BIAS     = 3'd4;

    // reset values
    localparam logic [SIZE_BITS-1:0]  RST_FRAME_WIDTH  = 11'd100;
    localparam logic [SIZE_BITS-1:0]  RST_FRAME_HEIGHT = 11'd100;
    localparam logic [TAPS_BITS-1:0]  RST_KERNEL_TAPS  = 36'd4042649840;
    localparam logic [SCALE_BITS-1:0] RST_TAP_SCALE    = 16'd262;
    localparam logic [BIAS_BITS-1:0]  RST_TAP_BIAS     = 20'd65536;

    // operation codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic load;   // latch the accepted pixel
        logic shift;  // line store write, window shift, input advance
        logic sum;    // register the tap-weighted sum
        logic mul;    // register the scaled sum
        logic emit;   // load the output register, advance output position
    } t_cmd;

    typedef struct packed {
        logic in_full;   // whole frame received
        logic due;       // current pixel releases a result
        logic out_free;  // output register can take a result this cycle
    } t_sts;

endpackage

`default_nettype wire

// ----- design/cnv3_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the two rows of the line store.
`default_nettype none

module cnv3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/cnv3_datapath.sv -----
// Datapath of the 3x3 convolution: config registers, line store, window,
// position counters, multiply-accumulate and output register. Uses cnv3_pkg, cnv3_ram.
`default_nettype none

module cnv3_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [cnv3_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [cnv3_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  wire logic [cnv3_pkg::PIXEL_PORT_BITS-1:0]  i_pixel,
    input  wire cnv3_pkg::t_cmd                        i_cmd,
    output      cnv3_pkg::t_sts                        o_sts,
    input  wire logic                                  i_out_stall,
    output      logic                                  o_out_valid,
    output      logic signed [cnv3_pkg::VALUE_BITS-1:0] o_value,
    output      logic                                  o_is_border,
    output      logic                                  o_last_of_frame
);

    import cnv3_pkg::*;

    `include "assert_macros.svh"

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int PB = PIXEL_BITS;
    localparam int SW = PB + 8;                   // nine taps of 4 bits times PB
    localparam int TW = PB + 5;                   // one tap product
    localparam int PW = SW + SCALE_BITS + 1;      // scaled sum
    localparam int XW = (PW + 1 > VALUE_BITS + 1) ? PW + 1 : VALUE_BITS + 1;
    localparam logic [SIZE_BITS-1:0] WIDTH_CAP =
        SIZE_BITS'((MAX_WIDTH < SIZE_MAX) ? MAX_WIDTH : SIZE_MAX);
    localparam logic [SIZE_BITS-1:0] HEIGHT_CAP = SIZE_BITS'(SIZE_MAX);
    localparam logic [SIZE_BITS-1:0] SZ_MIN     = SIZE_BITS'(SIZE_MIN);
    localparam logic signed [XW-1:0] VAL_MAX =
        {{(XW - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
    localparam logic signed [XW-1:0] VAL_MIN =
        {{(XW - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}};

    // configuration
    logic [SIZE_BITS-1:0]  r_frame_width;
    logic [SIZE_BITS-1:0]  r_frame_height;
    logic [TAPS_BITS-1:0]  r_kernel_taps;
    logic [SCALE_BITS-1:0] r_tap_scale;
    logic [BIAS_BITS-1:0]  r_tap_bias;
    logic [SIZE_BITS-1:0]  eff_w;
    logic [SIZE_BITS-1:0]  eff_h;
    logic                  cfg_restart;

    // positions and window
    logic [SIZE_BITS-1:0]  r_in_col,  n_in_col;
    logic [SIZE_BITS-1:0]  r_in_row,  n_in_row;
    logic [SIZE_BITS-1:0]  r_out_col, n_out_col;
    logic [SIZE_BITS-1:0]  r_out_row, n_out_row;
    logic [PB-1:0]         r_win [TAP_COUNT];
    logic [PB-1:0]         n_win [TAP_COUNT];
    logic [PB-1:0]         r_pix;
    logic signed [VALUE_BITS-1:0] r_last_int, n_last_int;

    // line store
    logic [PB-1:0]         rd_top;
    logic [PB-1:0]         rd_mid;
    logic [PB-1:0]         top_px;
    logic [PB-1:0]         mid_px;
    logic [AW-1:0]         col_addr;

    // arithmetic
    logic signed [TAP_BITS-1:0] tap [TAP_COUNT];
    logic signed [TW-1:0]  term [TAP_COUNT];
    logic signed [SW-1:0]  sum_c;
    logic signed [SW-1:0]  r_sum;
    logic signed [PW-1:0]  r_prod;
    logic [BIAS9_BITS-1:0] bias9;
    logic signed [XW-1:0]  acc;
    logic signed [VALUE_BITS-1:0] filt;

    // output position decode
    logic                  out_interior;
    logic                  out_last;
    logic                  frame_end;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic signed [VALUE_BITS-1:0] r_value;
    logic                  r_is_border;
    logic                  r_last_of_frame;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_kernel_taps  <= RST_KERNEL_TAPS;
            r_tap_scale    <= RST_TAP_SCALE;
            r_tap_bias     <= RST_TAP_BIAS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[SIZE_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[SIZE_BITS-1:0];
                CFG_KERNEL_TAPS:  r_kernel_taps  <= i_cfg_data[TAPS_BITS-1:0];
                CFG_TAP_SCALE:    r_tap_scale    <= i_cfg_data[SCALE_BITS-1:0];
                CFG_TAP_BIAS:     r_tap_bias     <= i_cfg_data[BIAS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg_restart = i_cfg_we &&
        (i_cfg_index == CFG_FRAME_WIDTH || i_cfg_index == CFG_FRAME_HEIGHT);

    always_comb begin
        if (r_frame_width < SZ_MIN) begin
            eff_w = SZ_MIN;
        end else if (r_frame_width > WIDTH_CAP) begin
            eff_w = WIDTH_CAP;
        end else begin
            eff_w = r_frame_width;
        end
        if (r_frame_height < SZ_MIN) begin
            eff_h = SZ_MIN;
        end else if (r_frame_height > HEIGHT_CAP) begin
            eff_h = HEIGHT_CAP;
        end else begin
            eff_h = r_frame_height;
        end
    end

    // ---------------- line store ----------------
    // Two rows of samples: top row holds row r-2, mid row holds row r-1.
    assign col_addr = AW'(r_in_col);
    assign top_px   = (r_in_row >= SIZE_BITS'(2)) ? rd_top : '0;
    assign mid_px   = (r_in_row >= SIZE_BITS'(1)) ? rd_mid : '0;

    cnv3_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_top_row (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (col_addr),
        .i_wdata (mid_px),
        .i_raddr (col_addr),
        .o_rdata (rd_top)
    );

    cnv3_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_mid_row (
        .i_clk   (i_clk),
        .i_we    (i_cmd.shift),
        .i_waddr (col_addr),
        .i_wdata (r_pix),
        .i_raddr (col_addr),
        .o_rdata (rd_mid)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= PB'(i_pixel);
        end
    end

    // ---------------- output position decode ----------------
    assign out_interior = (r_out_row >= SIZE_BITS'(1)) && (r_out_row <= eff_h - SIZE_BITS'(2))
                       && (r_out_col >= SIZE_BITS'(1)) && (r_out_col <= eff_w - SIZE_BITS'(2));
    assign out_last  = (r_out_row == eff_h - SIZE_BITS'(1))
                    && (r_out_col == eff_w - SIZE_BITS'(1));
    assign frame_end = i_cmd.emit && out_last;

    // ---------------- positions, window, last interior ----------------
    always_comb begin
        n_in_col    = r_in_col;
        n_in_row    = r_in_row;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        n_last_int  = r_last_int;
        n_win       = r_win;
        if (i_cmd.shift) begin
            if (r_in_col == eff_w - SIZE_BITS'(1)) begin
                n_in_col = '0;
                n_in_row = r_in_row + SIZE_BITS'(1);
            end else begin
                n_in_col = r_in_col + SIZE_BITS'(1);
            end
            for (int r = 0; r < 3; r++) begin
                n_win[3*r]     = r_win[3*r + 1];
                n_win[3*r + 1] = r_win[3*r + 2];
            end
            n_win[2] = top_px;
            n_win[5] = mid_px;
            n_win[8] = r_pix;
        end
        if (i_cmd.emit) begin
            if (r_out_col == eff_w - SIZE_BITS'(1)) begin
                n_out_col = '0;
                n_out_row = r_out_row + SIZE_BITS'(1);
            end else begin
                n_out_col = r_out_col + SIZE_BITS'(1);
            end
            if (out_interior) begin
                n_last_int = filt;
            end
        end
        if (cfg_restart || frame_end) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_last_int = '0;
            for (int k = 0; k < TAP_COUNT; k++) begin
                n_win[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_last_int <= '0;
            for (int k = 0; k < TAP_COUNT; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_last_int <= n_last_int;
            r_win      <= n_win;
        end
    end

    // ---------------- multiply-accumulate ----------------
    always_comb begin
        sum_c = '0;
        for (int k = 0; k < TAP_COUNT; k++) begin
            tap[k]  = $signed(r_kernel_taps[k*TAP_BITS +: TAP_BITS]);
            term[k] = TW'(tap[k]) * TW'($signed({1'b0, r_win[k]}));
            sum_c   = sum_c + SW'(term[k]);
        end
    end

    assign bias9 = BIAS9_BITS'({r_tap_bias, 3'b000}) + BIAS9_BITS'(r_tap_bias);
    assign acc   = XW'(r_prod) + XW'($signed({1'b0, bias9}));

    always_comb begin
        if (acc > VAL_MAX) begin
            filt = VAL_MAX[VALUE_BITS-1:0];
        end else if (acc < VAL_MIN) begin
            filt = VAL_MIN[VALUE_BITS-1:0];
        end else begin
            filt = acc[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum) begin
            r_sum <= sum_c;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_sum) * PW'($signed({1'b0, r_tap_scale}));
        end
    end

    // ---------------- output register ----------------
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_value         <= out_interior ? filt : r_last_int;
            r_is_border     <= !out_interior;
            r_last_of_frame <= out_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_value         = r_value;
    assign o_is_border     = r_is_border;
    assign o_last_of_frame = r_last_of_frame;

    // ---------------- status ----------------
    assign o_sts.in_full  = (r_in_row == eff_h);
    assign o_sts.due      = (r_in_row >= SIZE_BITS'(2))
                         || ((r_in_row == SIZE_BITS'(1)) && (r_in_col != '0));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_in_col_bound, i_clk, i_rst_n, r_in_col < eff_w, "input column past width")
    `ASSERT_CLK(a_out_behind_in, i_clk, i_rst_n, r_out_row <= r_in_row, "output ahead of input")
    `ASSERT_CLK(a_frame_end_clear, i_clk, i_rst_n,
        frame_end |=> (r_in_row == '0) && (r_in_col == '0) && (r_out_row == '0),
        "positions not cleared at frame end")

endmodule

`default_nettype wire

// ----- design/cnv3_ctrl.sv -----
// Controller of the 3x3 convolution: input handshake and per-item sequence.
// Uses cnv3_pkg; drives the datapath by command, reads its status.
`default_nettype none

module cnv3_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire logic           i_operation,
    output      logic           o_in_stall,
    input  wire cnv3_pkg::t_sts i_sts,
    output      cnv3_pkg::t_cmd o_cmd
);

    import cnv3_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SUM  = 5'b00100,
        S_MUL  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_PIXEL && !i_sts.in_full) begin
                        n_state = S_READ;
                    end else if (i_sts.in_full) begin
                        // frame complete (a flush or a pixel past frame end): release one result
                        n_state = S_SUM;
                    end
                end
            end
            S_READ: begin
                n_state = i_sts.due ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cmd.load  = accept;
    assign o_cmd.shift = (r_state == S_READ);
    assign o_cmd.sum   = (r_state == S_SUM);
    assign o_cmd.mul   = (r_state == S_MUL);
    assign o_cmd.emit  = (r_state == S_EMIT) && i_sts.out_free;

    `ASSERT_CLK(a_emit_waits, i_clk, i_rst_n,
        (r_state == S_EMIT) && !i_sts.out_free |=> r_state == S_EMIT,
        "result dropped while output register busy")
    `ASSERT_NEVER(a_read_not_full, i_clk, i_rst_n,
        (r_state == S_READ) && i_sts.in_full, "line store access after frame complete")
    `ASSERT_CLK(a_state_onehot, i_clk, i_rst_n, $onehot(r_state), "state register not one-hot")

endmodule

`default_nettype wire

// ----- design/image_convolution_3x3.sv -----
// Top level of the 3x3 convolution block.
// Uses cnv3_pkg, cnv3_ctrl, cnv3_datapath (which holds two cnv3_ram rows).
`default_nettype none

// Streams a raster-order frame through a 3x3 kernel in Q.16 fixed point and
// returns one result per pixel, in raster order, lagging the input by
// width+1 beats; send width+1 flush beats after the last pixel to drain the
// frame. Border results repeat the last interior value (0 before the first).
// The block takes one beat at a time: each pixel goes through line store read
// and window shift, and one that releases a result then through tap sum, scale
// multiply, bias add and saturate; a draining beat goes through the latter
// only, and a flush before the frame is complete is just accepted. A result
// waiting in the output register does not hold up the next beat unless
// another result is ready behind it. The line store needs no clearing pass
// after reset. Configuration must be written only while the block is idle;
// the block does not enforce it; writing width or height restarts the frame.
module image_convolution_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [cnv3_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [cnv3_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  wire logic                                   i_in_valid,
    output      logic                                   o_in_stall,
    input  wire logic                                   i_operation,
    input  wire logic [cnv3_pkg::PIXEL_PORT_BITS-1:0]   i_pixel,
    output      logic                                   o_out_valid,
    input  wire logic                                   i_out_stall,
    output      logic signed [cnv3_pkg::VALUE_BITS-1:0] o_value,
    output      logic                                   o_is_border,
    output      logic                                   o_last_of_frame
);

    import cnv3_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cnv3_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cnv3_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pixel         (i_pixel),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_value         (o_value),
        .o_is_border     (o_is_border),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule

`default_nettype wire
